@@ src/csq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor sequencer package
// Shared constants, command and mode codes, and the result record.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int DELAY_BITS_DEF   = 16;
    localparam int CURRENT_BITS_DEF = 24;
    localparam int KIND_W           = 3;
    localparam int MODE_W           = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK        = 3'd0,
        KIND_CLOSE_NOW   = 3'd1,
        KIND_CLOSE_DLY   = 3'd2,
        KIND_OPEN_NOW    = 3'd3,
        KIND_OPEN_DLY    = 3'd4,
        KIND_OPEN_ON_CUR = 3'd5
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OPEN       = 3'd0,
        MODE_CLOSED     = 3'd1,
        MODE_WAIT_CLOSE = 3'd2,
        MODE_WAIT_OPEN  = 3'd3,
        MODE_WAIT_CUR   = 3'd4,
        MODE_FAULT      = 3'd5
    } mode_t;

    typedef struct packed {
        logic  coil_drive;
        mode_t mode;
        logic  close_failed;
        logic  open_failed;
    } res_t;

endpackage

@@ src/csq_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor sequencer command channel
// Valid/ready channel carrying one command or tick with its operands.
// ----------------------------------------------------------------------------
interface csq_cmd_if #(
    parameter int DELAY_BITS   = csq_pkg::DELAY_BITS_DEF,
    parameter int CURRENT_BITS = csq_pkg::CURRENT_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [csq_pkg::KIND_W-1:0]     kind;
    logic [DELAY_BITS-1:0]          delay_ms;
    logic signed [CURRENT_BITS-1:0] current_threshold;
    logic signed [CURRENT_BITS-1:0] measured_current;
    logic                           readback_after_close;
    logic                           readback_after_open;

    modport source (
        output valid, kind, delay_ms, current_threshold, measured_current,
               readback_after_close, readback_after_open,
        input  ready
    );
    modport sink (
        input  valid, kind, delay_ms, current_threshold, measured_current,
               readback_after_close, readback_after_open,
        output ready
    );
endinterface

@@ src/csq_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor sequencer result channel
// Valid/ready channel carrying the coil level, mode and failure flags.
// ----------------------------------------------------------------------------
interface csq_res_if;
    logic                       valid;
    logic                       ready;
    logic                       coil_drive;
    logic [csq_pkg::MODE_W-1:0] contactor_mode;
    logic                       close_failed;
    logic                       open_failed;

    modport source (
        output valid, coil_drive, contactor_mode, close_failed, open_failed,
        input  ready
    );
    modport sink (
        input  valid, coil_drive, contactor_mode, close_failed, open_failed,
        output ready
    );
endinterface

@@ src/csq_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor sequencer input register
// Captures one command transfer and holds it until the core can take it.
// ----------------------------------------------------------------------------
module csq_in_stage #(
    parameter int DELAY_BITS   = csq_pkg::DELAY_BITS_DEF,
    parameter int CURRENT_BITS = csq_pkg::CURRENT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    csq_cmd_if.sink                        cmd,
    input  logic                           advance,
    output logic                           item_valid,
    output logic [csq_pkg::KIND_W-1:0]     kind,
    output logic [DELAY_BITS-1:0]          delay_ms,
    output logic signed [CURRENT_BITS-1:0] current_threshold,
    output logic signed [CURRENT_BITS-1:0] measured_current,
    output logic                           readback_after_close,
    output logic                           readback_after_open
);
    import csq_pkg::*;

    logic                           valid_reg, valid_next;
    logic [KIND_W-1:0]              kind_reg;
    logic [DELAY_BITS-1:0]          delay_reg;
    logic signed [CURRENT_BITS-1:0] thr_reg;
    logic signed [CURRENT_BITS-1:0] cur_reg;
    logic                           rbc_reg;
    logic                           rbo_reg;
    logic                           take;

    // The register frees up in the same cycle that the core consumes its item.
    assign cmd.ready = !valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= cmd.kind;
            delay_reg <= cmd.delay_ms;
            thr_reg   <= cmd.current_threshold;
            cur_reg   <= cmd.measured_current;
            rbc_reg   <= cmd.readback_after_close;
            rbo_reg   <= cmd.readback_after_open;
        end
    end

    assign item_valid           = valid_reg;
    assign kind                 = kind_reg;
    assign delay_ms             = delay_reg;
    assign current_threshold    = thr_reg;
    assign measured_current     = cur_reg;
    assign readback_after_close = rbc_reg;
    assign readback_after_open  = rbo_reg;

endmodule

@@ src/csq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor sequencer core
// Holds mode, countdown, current limit and coil level; applies one item.
// ----------------------------------------------------------------------------
module csq_core #(
    parameter int DELAY_BITS   = csq_pkg::DELAY_BITS_DEF,
    parameter int CURRENT_BITS = csq_pkg::CURRENT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [csq_pkg::KIND_W-1:0]     kind,
    input  logic [DELAY_BITS-1:0]          delay_ms,
    input  logic signed [CURRENT_BITS-1:0] current_threshold,
    input  logic signed [CURRENT_BITS-1:0] measured_current,
    input  logic                           readback_after_close,
    input  logic                           readback_after_open,
    output csq_pkg::res_t                  res
);
    import csq_pkg::*;

    mode_t                          mode_reg, mode_next;
    logic [DELAY_BITS-1:0]          rem_reg, rem_next;
    logic signed [CURRENT_BITS-1:0] lim_reg, lim_next;
    logic                           drive_reg, drive_next;
    logic                           do_close;
    logic                           do_open;
    logic                           close_fail;
    logic                           open_fail;
    logic                           rem_zero;
    logic                           cur_below;

    assign rem_zero  = (rem_reg == '0);
    assign cur_below = (measured_current < lim_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        rem_next   = rem_reg;
        lim_next   = lim_reg;
        drive_next = drive_reg;
        do_close   = 1'b0;
        do_open    = 1'b0;
        close_fail = 1'b0;
        open_fail  = 1'b0;

        case (kind_t'(kind))
            KIND_TICK:
            begin
                case (mode_reg)
                    MODE_WAIT_CLOSE:
                    begin
                        if (rem_zero)
                        begin
                            do_close = 1'b1;
                        end
                        else
                        begin
                            rem_next = rem_reg - DELAY_BITS'(1);
                        end
                    end
                    MODE_WAIT_OPEN:
                    begin
                        if (rem_zero)
                        begin
                            do_open = 1'b1;
                        end
                        else
                        begin
                            rem_next = rem_reg - DELAY_BITS'(1);
                        end
                    end
                    MODE_WAIT_CUR:
                    begin
                        if (cur_below || rem_zero)
                        begin
                            do_open = 1'b1;
                        end
                        else
                        begin
                            rem_next = rem_reg - DELAY_BITS'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            KIND_CLOSE_NOW:
            begin
                do_close = 1'b1;
            end
            KIND_CLOSE_DLY:
            begin
                if (mode_reg != MODE_CLOSED)
                begin
                    mode_next = MODE_WAIT_CLOSE;
                    rem_next  = delay_ms;
                end
            end
            KIND_OPEN_NOW:
            begin
                do_open = 1'b1;
            end
            KIND_OPEN_DLY:
            begin
                if (mode_reg != MODE_OPEN)
                begin
                    mode_next = MODE_WAIT_OPEN;
                    rem_next  = delay_ms;
                end
            end
            KIND_OPEN_ON_CUR:
            begin
                if (mode_reg != MODE_OPEN)
                begin
                    mode_next = MODE_WAIT_CUR;
                    lim_next  = current_threshold;
                    rem_next  = delay_ms;
                end
            end
            default:
            begin
            end
        endcase

        // A close that reads back low falls through to an open attempt.
        if (do_close)
        begin
            drive_next = 1'b1;
            rem_next   = '0;
            if (readback_after_close)
            begin
                mode_next = MODE_CLOSED;
            end
            else
            begin
                close_fail = 1'b1;
                do_open    = 1'b1;
            end
        end

        if (do_open)
        begin
            drive_next = 1'b0;
            rem_next   = '0;
            lim_next   = '0;
            if (readback_after_open)
            begin
                open_fail = 1'b1;
                mode_next = MODE_FAULT;
            end
            else
            begin
                mode_next = MODE_OPEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OPEN;
            rem_reg   <= '0;
            lim_reg   <= '0;
            drive_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            rem_reg   <= rem_next;
            lim_reg   <= lim_next;
            drive_reg <= drive_next;
        end
    end

    assign res.coil_drive   = drive_next;
    assign res.mode         = mode_next;
    assign res.close_failed = close_fail;
    assign res.open_failed  = open_fail;

`ifndef ASSERT_OFF
    a_open_fail_faults: assert property (@(posedge clk) disable iff (!rst_n)
        fire && open_fail |=> mode_reg == MODE_FAULT)
        else $error("failed open did not enter fault mode");

    a_close_fail_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        fire && close_fail |=> !drive_reg)
        else $error("failed close left the coil driven");

    a_open_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_OPEN |-> rem_reg == '0 && lim_reg == '0)
        else $error("open mode with live countdown or current limit");

    a_closed_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_CLOSED |-> rem_reg == '0 && drive_reg)
        else $error("closed mode with countdown running or coil off");
`endif

endmodule

@@ src/csq_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor sequencer result register
// Holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module csq_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  csq_pkg::res_t res_in,
    output logic          advance,
    csq_res_if.source     res
);
    import csq_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // The register may load whenever it is empty or being emptied this cycle.
    assign advance = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            res_reg <= res_in;
        end
    end

    assign res.valid          = valid_reg;
    assign res.coil_drive     = res_reg.coil_drive;
    assign res.contactor_mode = res_reg.mode;
    assign res.close_failed   = res_reg.close_failed;
    assign res.open_failed    = res_reg.open_failed;

endmodule

@@ src/contactor_sequencer.sv @@
`timescale 1ns / 1ps
// A command transfer loads the input register; the core applies it as it
// moves into the result register, from which the result is offered.
// Throughput: one item per cycle while the result sink is ready; the state
// update is a compare and decrement between the input and result registers.
// Reset: rst_n clears both stage valid bits, puts the contactor in open mode
// with the coil off, and zeroes the countdown and the current limit.
// ----------------------------------------------------------------------------
// Contactor sequencer top level
// Command and tick sequencing for one contactor coil with readback checks.
// ----------------------------------------------------------------------------
module contactor_sequencer #(
    parameter int DELAY_BITS   = csq_pkg::DELAY_BITS_DEF,
    parameter int CURRENT_BITS = csq_pkg::CURRENT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    csq_cmd_if.sink    cmd,
    csq_res_if.source  res
);
    import csq_pkg::*;

    logic                           advance;
    logic                           item_valid;
    logic [KIND_W-1:0]              kind;
    logic [DELAY_BITS-1:0]          delay_ms;
    logic signed [CURRENT_BITS-1:0] current_threshold;
    logic signed [CURRENT_BITS-1:0] measured_current;
    logic                           readback_after_close;
    logic                           readback_after_open;
    res_t                           core_res;

    csq_in_stage #(
        .DELAY_BITS   (DELAY_BITS),
        .CURRENT_BITS (CURRENT_BITS)
    ) u_in_stage (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .advance              (advance),
        .item_valid           (item_valid),
        .kind                 (kind),
        .delay_ms             (delay_ms),
        .current_threshold    (current_threshold),
        .measured_current     (measured_current),
        .readback_after_close (readback_after_close),
        .readback_after_open  (readback_after_open)
    );

    csq_core #(
        .DELAY_BITS   (DELAY_BITS),
        .CURRENT_BITS (CURRENT_BITS)
    ) u_core (
        .clk                  (clk),
        .rst_n                (rst_n),
        .fire                 (item_valid && advance),
        .kind                 (kind),
        .delay_ms             (delay_ms),
        .current_threshold    (current_threshold),
        .measured_current     (measured_current),
        .readback_after_close (readback_after_close),
        .readback_after_open  (readback_after_open),
        .res                  (core_res)
    );

    csq_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res_in     (core_res),
        .advance    (advance),
        .res        (res)
    );

endmodule

@@ tb/sv/tb_contactor_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor sequencer testbench
// Drives commands and ticks into the sequencer and keeps its own model of the
// coil, mode, countdown and current limit. Every result transfer is compared
// with the next predicted one. Directed checks cover the immediate, delayed
// and current-threshold commands. Random command sequences then run under
// three patterns of source and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_contactor_sequencer;
    import csq_pkg::*;

    localparam logic signed [23:0] CUR_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CUR_MIN = 24'sh800000;

    logic clk;
    logic rst_n;

    csq_cmd_if #(.DELAY_BITS(16), .CURRENT_BITS(24)) cmd_ch ();
    csq_res_if res_ch ();

    contactor_sequencer #(.DELAY_BITS(16), .CURRENT_BITS(24)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Model of the sequencer state.
    mode_t              coil_mode;
    logic [15:0]        coil_countdown;
    logic signed [23:0] coil_limit;
    logic               coil_level;

    res_t pending_results[$];

    int source_idle_pct;
    int sink_idle_pct;
    int errors;
    int commands_sent;
    int results_checked;
    int close_fail_seen;
    int open_fail_seen;
    int fault_seen;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: results still outstanding");
        $display("TEST FAILED");
        $finish;
    end

    function automatic res_t predict_coil(kind_t k, logic [15:0] dly,
                                          logic signed [23:0] thr,
                                          logic signed [23:0] cur,
                                          logic rb_close, logic rb_open);
        logic close_fail;
        logic open_fail;
        logic do_close;
        logic do_open;
        res_t r;
        close_fail = 1'b0;
        open_fail  = 1'b0;
        do_close   = 1'b0;
        do_open    = 1'b0;
        case (k)
            KIND_TICK:
            begin
                if (coil_mode == MODE_WAIT_CLOSE)
                begin
                    if (coil_countdown == 16'd0) do_close = 1'b1;
                    else coil_countdown = coil_countdown - 16'd1;
                end
                else if (coil_mode == MODE_WAIT_OPEN)
                begin
                    if (coil_countdown == 16'd0) do_open = 1'b1;
                    else coil_countdown = coil_countdown - 16'd1;
                end
                else if (coil_mode == MODE_WAIT_CUR)
                begin
                    if (cur < coil_limit || coil_countdown == 16'd0) do_open = 1'b1;
                    else coil_countdown = coil_countdown - 16'd1;
                end
            end
            KIND_CLOSE_NOW: do_close = 1'b1;
            KIND_CLOSE_DLY:
            begin
                if (coil_mode != MODE_CLOSED)
                begin
                    coil_mode      = MODE_WAIT_CLOSE;
                    coil_countdown = dly;
                end
            end
            KIND_OPEN_NOW: do_open = 1'b1;
            KIND_OPEN_DLY:
            begin
                if (coil_mode != MODE_OPEN)
                begin
                    coil_mode      = MODE_WAIT_OPEN;
                    coil_countdown = dly;
                end
            end
            KIND_OPEN_ON_CUR:
            begin
                if (coil_mode != MODE_OPEN)
                begin
                    coil_mode      = MODE_WAIT_CUR;
                    coil_limit     = thr;
                    coil_countdown = dly;
                end
            end
            default: ;
        endcase
        // A close that reads back low falls through to an open attempt.
        if (do_close)
        begin
            coil_level     = 1'b1;
            coil_countdown = 16'd0;
            if (!rb_close)
            begin
                close_fail = 1'b1;
                do_open    = 1'b1;
            end
            else
            begin
                coil_mode = MODE_CLOSED;
            end
        end
        if (do_open)
        begin
            coil_level     = 1'b0;
            coil_countdown = 16'd0;
            coil_limit     = '0;
            if (rb_open)
            begin
                open_fail = 1'b1;
                coil_mode = MODE_FAULT;
            end
            else
            begin
                coil_mode = MODE_OPEN;
            end
        end
        r.coil_drive   = coil_level;
        r.mode         = coil_mode;
        r.close_failed = close_fail;
        r.open_failed  = open_fail;
        return r;
    endfunction

    function automatic bit field_ok(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return got === want;
    endfunction

    // Results are checked before the command taken at the same edge is predicted;
    // with the input and result registers between, the two can never belong together.
    always @(posedge clk)
    begin : check_and_predict
        res_t want;
        bit   ok;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, actual %0d/%0d/%0d/%0d",
                         $time, res_ch.coil_drive, res_ch.contactor_mode,
                         res_ch.close_failed, res_ch.open_failed);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                ok = field_ok("coil_drive", 3'(want.coil_drive), 3'(res_ch.coil_drive));
                ok = field_ok("contactor_mode", want.mode, res_ch.contactor_mode) && ok;
                ok = field_ok("close_failed", 3'(want.close_failed),
                              3'(res_ch.close_failed)) && ok;
                ok = field_ok("open_failed", 3'(want.open_failed),
                              3'(res_ch.open_failed)) && ok;
                if (!ok) errors++;
                results_checked++;
                if (want.close_failed) close_fail_seen++;
                if (want.open_failed) open_fail_seen++;
                if (want.mode == MODE_FAULT) fault_seen++;
            end
        end
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            pending_results.push_back(predict_coil(kind_t'(cmd_ch.kind), cmd_ch.delay_ms,
                                                   cmd_ch.current_threshold,
                                                   cmd_ch.measured_current,
                                                   cmd_ch.readback_after_close,
                                                   cmd_ch.readback_after_open));
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Returns just after the edge at which the item was transferred.
    task automatic send_item(kind_t k, logic [15:0] dly, logic signed [23:0] thr,
                             logic signed [23:0] cur, logic rb_close, logic rb_open);
        while ($urandom_range(0, 99) < source_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid                <= 1'b1;
        cmd_ch.kind                 <= k;
        cmd_ch.delay_ms             <= dly;
        cmd_ch.current_threshold    <= thr;
        cmd_ch.measured_current     <= cur;
        cmd_ch.readback_after_close <= rb_close;
        cmd_ch.readback_after_open  <= rb_open;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        commands_sent++;
    endtask

    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic noisy_readback(logic good);
        return ($urandom_range(0, 99) < 88) ? good : logic'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 4));
        if (r < 90) return 16'($urandom_range(5, 12));
        return 16'($urandom);
    endfunction

    function automatic logic signed [23:0] pick_current(logic signed [23:0] thr);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 24'($urandom);
        if (r < 35) return ($urandom_range(0, 1) != 0) ? CUR_MAX : CUR_MIN;
        // Mostly at or just above the limit, now and then one below it.
        return thr + 24'($signed($urandom_range(0, 6)) - 1);
    endfunction

    task automatic test_immediate_commands();
        send_item(KIND_CLOSE_NOW, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_OPEN_NOW, 16'd0, 24'sd0, 24'sd0, 1'b0, 1'b0);
        // Close that reads back low, then the fallback open succeeds.
        send_item(KIND_CLOSE_NOW, 16'd0, 24'sd0, 24'sd0, 1'b0, 1'b0);
        // Close and fallback open both fail: fault.
        send_item(KIND_CLOSE_NOW, 16'd0, 24'sd0, 24'sd0, 1'b0, 1'b1);
        // Idle tick in fault must ignore the readbacks.
        send_item(KIND_TICK, 16'hFFFF, CUR_MIN, CUR_MAX, 1'b0, 1'b1);
        send_item(KIND_OPEN_NOW, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b1);
        send_item(KIND_OPEN_NOW, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
    endtask

    task automatic test_delayed_commands();
        send_item(KIND_OPEN_DLY, 16'd3, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_CLOSE_DLY, 16'hFFFF, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_TICK, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_CLOSE_NOW, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_CLOSE_DLY, 16'd2, 24'sd0, 24'sd0, 1'b1, 1'b0);
        // Fires on the second tick.
        send_item(KIND_OPEN_DLY, 16'd1, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_TICK, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b1);
        send_item(KIND_TICK, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
        // From fault a delayed close still starts the wait.
        send_item(KIND_OPEN_NOW, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b1);
        send_item(KIND_CLOSE_DLY, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_TICK, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
    endtask

    task automatic test_open_on_current();
        send_item(KIND_OPEN_ON_CUR, 16'hFFFF, CUR_MAX, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_TICK, 16'd0, 24'sd0, CUR_MIN, 1'b1, 1'b0);
        send_item(KIND_OPEN_ON_CUR, 16'd5, CUR_MAX, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_CLOSE_NOW, 16'd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
        // Equal current is not below the limit, so only the timeout opens.
        send_item(KIND_OPEN_ON_CUR, 16'd1, CUR_MIN, 24'sd0, 1'b1, 1'b0);
        send_item(KIND_TICK, 16'd0, 24'sd0, CUR_MIN, 1'b1, 1'b0);
        send_item(KIND_TICK, 16'd0, 24'sd0, CUR_MAX, 1'b1, 1'b1);
    endtask

    task automatic test_random_sequences(int n_items, int src_pct, int snk_pct);
        int                 sent;
        int                 n_ticks;
        kind_t              k;
        logic [15:0]        dly;
        logic signed [23:0] thr;
        source_idle_pct = src_pct;
        sink_idle_pct   = snk_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 2))
                    0: k = KIND_CLOSE_DLY;
                    1: k = KIND_OPEN_DLY;
                    default: k = KIND_OPEN_ON_CUR;
                endcase
                dly = pick_delay();
                thr = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                  : 24'($signed($urandom_range(0, 2000)) - 1000);
                // Put the contactor where the delayed command is not ignored.
                if ($urandom_range(0, 4) != 0)
                begin
                    send_item((k == KIND_CLOSE_DLY) ? KIND_OPEN_NOW : KIND_CLOSE_NOW,
                              16'($urandom), 24'($urandom), 24'($urandom),
                              noisy_readback(1'b1), noisy_readback(1'b0));
                    sent++;
                end
                send_item(k, dly, thr, 24'($urandom), noisy_readback(1'b1),
                          noisy_readback(1'b0));
                sent++;
                n_ticks = (dly < 16'd13) ? int'(dly) + $urandom_range(0, 2)
                                         : $urandom_range(0, 12);
                repeat (n_ticks)
                begin
                    send_item(KIND_TICK, 16'($urandom), 24'($urandom), pick_current(thr),
                              noisy_readback(1'b1), noisy_readback(1'b0));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_item(kind_t'($urandom_range(0, 5)), 16'($urandom), 24'($urandom),
                              24'($urandom), logic'($urandom_range(0, 1)),
                              logic'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n                       = 1'b0;
        cmd_ch.valid                = 1'b0;
        cmd_ch.kind                 = '0;
        cmd_ch.delay_ms             = '0;
        cmd_ch.current_threshold    = '0;
        cmd_ch.measured_current     = '0;
        cmd_ch.readback_after_close = 1'b0;
        cmd_ch.readback_after_open  = 1'b0;
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        errors          = 0;
        commands_sent   = 0;
        results_checked = 0;
        close_fail_seen = 0;
        open_fail_seen  = 0;
        fault_seen      = 0;
        coil_mode       = MODE_OPEN;
        coil_countdown  = '0;
        coil_limit      = '0;
        coil_level      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_immediate_commands();
        test_delayed_commands();
        test_open_on_current();
        // The sender holds off here until every outstanding result is back.
        wait_for_results();
        test_random_sequences(650, 31, 70);
        wait_for_results();
        test_random_sequences(650, 70, 31);
        wait_for_results();
        test_random_sequences(500, 0, 0);
        wait_for_results();

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors += pending_results.size();
        end
        $display("Sent %0d commands and ticks, checked %0d result transfers.",
                 commands_sent, results_checked);
        $display("Close failures %0d, open failures %0d, results in fault %0d.",
                 close_fail_seen, open_fail_seen, fault_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ contactor_sequencer.f @@
src/csq_pkg.sv
src/csq_cmd_if.sv
src/csq_res_if.sv
src/csq_in_stage.sv
src/csq_core.sv
src/csq_out_stage.sv
src/contactor_sequencer.sv
tb/sv/tb_contactor_sequencer.sv
